### design/dnge_pkg.sv
// Shared types and constants of the decimal number glyph emitter.
package dnge_pkg;

    // Input field widths
    localparam int VALUE_W  = 32;
    localparam int COORD_W  = 10;
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    // Output field widths
    localparam int DIGIT_W  = 4;
    localparam int FIX_W    = 13;
    localparam int TEX_W    = 16;
    localparam int CURSOR_W = 11;

    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [DIGIT_W-1:0]  digit_t;
    typedef logic [FIX_W-1:0]    fix_t;
    typedef logic [TEX_W-1:0]    tex_coord_t;
    typedef logic [CURSOR_W-1:0] cursor_t;

    // Glyph geometry: 8x8 cell, far edge inset by half a pixel in 11.2
    localparam fix_t    CELL_FAR_EDGE = fix_t'(30);
    localparam cursor_t DIGIT_ADVANCE = cursor_t'(7);

    // Digits sit in atlas row 3 (glyph row 1 plus offset 2): 3 * 8 << 5
    localparam tex_coord_t TEX_T_ORIGIN = tex_coord_t'(768);
    // Atlas column d gives d * 8 << 5, a shift of the digit by this much
    localparam int      TEX_S_SHIFT   = 8;

endpackage

### design/dnge_ifs.sv
// Handshake channels of the decimal number glyph emitter.
interface dnge_number_if
    import dnge_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t number_value;
    coord_t start_x;
    coord_t start_y;

    modport source (output valid, output number_value, output start_x, output start_y,
                    input ready);
    modport sink   (input valid, input number_value, input start_x, input start_y,
                    output ready);
endinterface

interface dnge_glyph_if
    import dnge_pkg::*;
();
    logic       valid;
    logic       ready;
    digit_t     digit_value;
    fix_t       rect_left;
    fix_t       rect_top;
    fix_t       rect_right;
    fix_t       rect_bottom;
    tex_coord_t tex_s;
    tex_coord_t tex_t;
    cursor_t    next_x;
    logic       last_digit;

    modport source (output valid, output digit_value, output rect_left, output rect_top,
                    output rect_right, output rect_bottom, output tex_s, output tex_t,
                    output next_x, output last_digit, input ready);
    modport sink   (input valid, input digit_value, input rect_left, input rect_top,
                    input rect_right, input rect_bottom, input tex_s, input tex_t,
                    input next_x, input last_digit, output ready);
endinterface

### design/decimal_number_glyph_emitter.sv
// Decimal number glyph emitter: binary to decimal conversion and glyph rectangle output.
//
// Each item on the number channel is converted to decimal by a bit-serial shift-and-add-3
// loop over a MAX_DIGITS-digit BCD shift register, one value bit a cycle.
// Leading zero digits are then shifted out one per cycle, and the remaining digits go out
// most significant first, one glyph item per cycle while the glyph channel takes them.
// A new number is taken once the last glyph of the previous one sits in the output register.
// A value with more than MAX_DIGITS decimal digits shows only its low MAX_DIGITS digits.
module decimal_number_glyph_emitter
    import dnge_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    dnge_number_if.sink   number,
    dnge_glyph_if.source  glyph
);

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int REM_W = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 ovf_reg, ovf_next;
    value_t               value_reg, value_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    cursor_t              cursor_reg, cursor_next;
    coord_t               y_reg, y_next;

    logic                 oval_reg, oval_next;
    digit_t               odigit_reg;
    fix_t                 oleft_reg, otop_reg, oright_reg, obottom_reg;
    tex_coord_t           otex_s_reg;
    cursor_t              onext_x_reg;
    logic                 olast_reg;

    logic [BCD_W-1:0]     bcd_adj;
    digit_t               top_digit;
    logic                 out_free;
    logic                 emit_fire;
    logic                 accept;
    logic                 is_last;
    cursor_t              cursor_adv;

    // Add 3 to every digit of 5 or more before the doubling shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= digit_t'(5))
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + digit_t'(3);
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    assign top_digit  = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign out_free   = !oval_reg || glyph.ready;
    assign emit_fire  = (state_reg == S_EMIT) && out_free;
    assign accept     = number.valid && number.ready;
    assign is_last    = (rem_reg == REM_W'(1));
    assign cursor_adv = cursor_reg + DIGIT_ADVANCE;

    assign number.ready = (state_reg == S_IDLE);

    // Sequence conversion, zero skipping and emission
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        value_next   = value_reg;
        bcd_next     = bcd_reg;
        cursor_next  = cursor_reg;
        y_next       = y_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next   = number.number_value;
                    cursor_next  = cursor_t'(number.start_x);
                    y_next       = number.start_y;
                    bcd_next     = '0;
                    ovf_next     = 1'b0;
                    bit_cnt_next = '0;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], value_reg[VALUE_W-1]};
                value_next   = {value_reg[VALUE_W-2:0], 1'b0};
                ovf_next     = ovf_reg | bcd_adj[BCD_W-1];
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    rem_next   = REM_W'(MAX_DIGITS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop a leading zero unless it is the only digit or digits overflowed
                if (top_digit == '0 && !is_last && !ovf_reg)
                begin
                    bcd_next = bcd_reg << DIGIT_W;
                    rem_next = rem_reg - REM_W'(1);
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    bcd_next    = bcd_reg << DIGIT_W;
                    rem_next    = rem_reg - REM_W'(1);
                    cursor_next = cursor_adv;
                    if (is_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid: load on emit, clear when taken
    always_comb
    begin
        oval_next = oval_reg;
        if (emit_fire)
            oval_next = 1'b1;
        else if (glyph.ready)
            oval_next = 1'b0;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
            rem_reg     <= '0;
            ovf_reg     <= 1'b0;
            cursor_reg  <= '0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
            cursor_reg  <= cursor_next;
            oval_reg    <= oval_next;
        end
    end

    // Hold working data
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        bcd_reg   <= bcd_next;
        y_reg     <= y_next;
    end

    // Load the glyph rectangle of the top digit
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            odigit_reg  <= top_digit;
            oleft_reg   <= {cursor_reg, 2'b00};
            otop_reg    <= fix_t'({y_reg, 2'b00});
            oright_reg  <= {cursor_reg, 2'b00} + CELL_FAR_EDGE;
            obottom_reg <= fix_t'({y_reg, 2'b00}) + CELL_FAR_EDGE;
            otex_s_reg  <= tex_coord_t'(top_digit) << TEX_S_SHIFT;
            onext_x_reg <= cursor_adv;
            olast_reg   <= is_last;
        end
    end

    assign glyph.valid       = oval_reg;
    assign glyph.digit_value = odigit_reg;
    assign glyph.rect_left   = oleft_reg;
    assign glyph.rect_top    = otop_reg;
    assign glyph.rect_right  = oright_reg;
    assign glyph.rect_bottom = obottom_reg;
    assign glyph.tex_s       = otex_s_reg;
    assign glyph.tex_t       = TEX_T_ORIGIN;
    assign glyph.next_x      = onext_x_reg;
    assign glyph.last_digit  = olast_reg;

`ifndef NO_ASSERTIONS
    // Conversion ends after exactly one pass over the value bits
    a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV && bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)) |=>
        (state_reg == S_SKIP))
        else $error("conversion did not end after the last value bit");

    // Every emitted digit is a decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        glyph.valid |-> (glyph.digit_value <= digit_t'(9)))
        else $error("emitted digit above nine");

    // Digit counter never runs dry while digits are pending
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP || state_reg == S_EMIT) |-> (rem_reg != '0))
        else $error("digit counter empty while skipping or emitting");

    // The last glyph returns the sequencer to idle and is marked last
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_last) |=> (state_reg == S_IDLE && glyph.valid && glyph.last_digit))
        else $error("last glyph not followed by idle");
`endif

endmodule
